[hw/rtl/nfr_pkg.sv]
`default_nettype none
package nfr_pkg;

	localparam int unsigned CRC_LEN = 17;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [7:0] HDR_BYTE = 8'h24;
	localparam logic [31:0] UNIT_LIMIT = 32'd99;
	localparam int unsigned CONN_LEN = 7;
	localparam int unsigned DISC_LEN = 10;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [1:0] ST_NO_LINK = 2'd0;
	localparam logic [1:0] ST_NO_HEADER = 2'd1;
	localparam logic [1:0] ST_BAD_CRC = 2'd2;
	localparam logic [1:0] ST_UPDATED = 2'd3;

	localparam logic [1:0] UNIT_M = 2'd1;
	localparam logic [1:0] UNIT_KM = 2'd2;

	// What the front hands over at the end of a frame
	typedef struct packed {
		logic        conn;
		logic        disc;
		logic        hdr_ok;
		logic [15:0] crc;
		logic [4:0]  pad;
		logic [15:0] rx_crc;
		logic [7:0]  dir_byte;
		logic [31:0] dist_m;
	} frame_sum_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] conn_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = "C";
			3'd1: ch = "o";
			3'd2: ch = "n";
			3'd3: ch = "n";
			3'd4: ch = "e";
			3'd5: ch = "c";
			3'd6: ch = "t";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] disc_char(input logic [3:0] idx);
		logic [7:0] ch;
		unique case (idx)
			4'd0: ch = "D";
			4'd1: ch = "i";
			4'd2: ch = "s";
			4'd3: ch = "c";
			4'd4: ch = "o";
			4'd5: ch = "n";
			4'd6: ch = "n";
			4'd7: ch = "e";
			4'd8: ch = "c";
			4'd9: ch = "t";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// {known, code}; unknown bytes keep the old direction
	function automatic logic [3:0] dir_map(input logic [7:0] b);
		logic [3:0] r;
		unique case (b)
			8'd1: r = {1'b1, 3'd4};
			8'd2: r = {1'b1, 3'd5};
			8'd3: r = {1'b1, 3'd6};
			8'd4: r = {1'b1, 3'd7};
			8'd6: r = {1'b1, 3'd3};
			8'd7: r = {1'b1, 3'd2};
			8'd8: r = {1'b1, 3'd1};
			default: r = {1'b0, 3'd0};
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/nfr_front.sv]
`default_nettype none
module nfr_front #(
	parameter int unsigned MAX_FRAME = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire logic [7:0]          data_byte,
	input  wire logic                frame_end,
	output logic                     push,
	output nfr_pkg::frame_sum_t      sum
);
	import nfr_pkg::*;

	localparam int unsigned PosW = $clog2(MAX_FRAME + 1);

	logic [PosW-1:0] pos_q, pos_nx;
	logic [15:0] crc_q, crc_nx;
	logic [31:0] dist_q, dist_nx;
	logic [7:0]  dir_q, dir_nx;
	logic [15:0] rx_q, rx_nx;
	logic        hdr_q, hdr_nx;
	logic [2:0]  cm_q, cm_nx;
	logic [3:0]  dm_q, dm_nx;
	logic        conn_q, conn_nx, disc_q, disc_nx, stop_q, stop_nx;
	logic        take;

	assign take = pos_q < PosW'(MAX_FRAME);

	always_comb begin
		pos_nx = pos_q;
		crc_nx = crc_q;
		dist_nx = dist_q;
		dir_nx = dir_q;
		rx_nx = rx_q;
		hdr_nx = hdr_q;
		cm_nx = cm_q;
		dm_nx = dm_q;
		conn_nx = conn_q;
		disc_nx = disc_q;
		stop_nx = stop_q;
		if (take) begin
			pos_nx = pos_q + PosW'(1);
			if (pos_q < PosW'(CRC_LEN))
				crc_nx = crc_byte(crc_q, data_byte);
			if (pos_q == PosW'(0))
				hdr_nx = (data_byte == HDR_BYTE);
			else if (pos_q == PosW'(1))
				hdr_nx = hdr_q && (data_byte == HDR_BYTE);
			else if (pos_q == PosW'(12))
				dir_nx = data_byte;
			else if (pos_q >= PosW'(13) && pos_q <= PosW'(16))
				dist_nx[8*(2'(pos_q - PosW'(13))) +: 8] = data_byte;
			else if (pos_q == PosW'(17))
				rx_nx[7:0] = data_byte;
			else if (pos_q == PosW'(18))
				rx_nx[15:8] = data_byte;
			// text search, ends at the first zero byte
			if (!stop_q) begin
				if (data_byte == 8'h00) begin
					stop_nx = 1'b1;
				end else begin
					if (!conn_q) begin
						if (data_byte == conn_char(cm_q))
							cm_nx = cm_q + 3'd1;
						else
							cm_nx = (data_byte == conn_char(3'd0)) ? 3'd1 : 3'd0;
						if (cm_nx == 3'(CONN_LEN))
							conn_nx = 1'b1;
					end
					if (!disc_q) begin
						if (data_byte == disc_char(dm_q))
							dm_nx = dm_q + 4'd1;
						else
							dm_nx = (data_byte == disc_char(4'd0)) ? 4'd1 : 4'd0;
						if (dm_nx == 4'(DISC_LEN))
							disc_nx = 1'b1;
					end
				end
			end
		end
	end

	assign push = accept && frame_end;

	always_comb begin
		sum.conn = conn_nx;
		sum.disc = disc_nx;
		sum.hdr_ok = hdr_nx && (pos_nx >= PosW'(2));
		sum.crc = crc_nx;
		sum.pad = (pos_nx < PosW'(CRC_LEN)) ? 5'(PosW'(CRC_LEN) - pos_nx) : 5'd0;
		sum.rx_crc = rx_nx;
		sum.dir_byte = dir_nx;
		sum.dist_m = dist_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= '0;
			dist_q <= '0;
			dir_q <= '0;
			rx_q <= '0;
			hdr_q <= 1'b0;
			cm_q <= '0;
			dm_q <= '0;
			conn_q <= 1'b0;
			disc_q <= 1'b0;
			stop_q <= 1'b0;
		end else if (accept) begin
			if (frame_end) begin
				// start the next frame clean
				pos_q <= '0;
				crc_q <= '0;
				dist_q <= '0;
				dir_q <= '0;
				rx_q <= '0;
				hdr_q <= 1'b0;
				cm_q <= '0;
				dm_q <= '0;
				conn_q <= 1'b0;
				disc_q <= 1'b0;
				stop_q <= 1'b0;
			end else begin
				pos_q <= pos_nx;
				crc_q <= crc_nx;
				dist_q <= dist_nx;
				dir_q <= dir_nx;
				rx_q <= rx_nx;
				hdr_q <= hdr_nx;
				cm_q <= cm_nx;
				dm_q <= dm_nx;
				conn_q <= conn_nx;
				disc_q <= disc_nx;
				stop_q <= stop_nx;
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/nfr_queue.sv]
`default_nettype none
module nfr_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire nfr_pkg::frame_sum_t wr_sum,
	output logic                     full,
	input  wire logic                pop,
	output logic                     head_valid,
	output nfr_pkg::frame_sum_t      head_sum
);
	import nfr_pkg::*;

	localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

	frame_sum_t     mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push, do_pop;

	assign full = cnt_q == CntW'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_sum = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= wr_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
			if (do_pop)
				rd_q <= (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CntW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CntW'(1);
		end
	end

endmodule
`default_nettype wire

[hw/rtl/nfr_back.sv]
`default_nettype none
module nfr_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                head_valid,
	input  wire nfr_pkg::frame_sum_t head_sum,
	output logic                     pop,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output logic [1:0]               status,
	output logic                     connected,
	output logic [2:0]               direction,
	output logic [31:0]              distance,
	output logic [1:0]               units
);
	import nfr_pkg::*;

	frame_sum_t  sum_q;
	logic        busy_q;
	logic [15:0] crc_q;
	logic [4:0]  pad_q;
	logic        link_q;
	logic [2:0]  turn_q;
	logic [31:0] dist_q;
	logic [1:0]  unit_q;
	logic        rv_q;
	logic [1:0]  st_q;
	logic        conn_out_q;
	logic [2:0]  dir_out_q;
	logic [31:0] dist_out_q;
	logic [1:0]  unit_out_q;

	logic        finish;
	logic        link_nx;
	logic [2:0]  turn_nx;
	logic [31:0] dist_nx;
	logic [1:0]  unit_nx;
	logic [1:0]  st_nx;
	logic [3:0]  dmap;

	assign finish = busy_q && pad_q == '0 && (!rv_q || result_ready);
	assign pop = head_valid && (!busy_q || finish);
	assign dmap = dir_map(sum_q.dir_byte);

	always_comb begin
		link_nx = link_q;
		turn_nx = turn_q;
		dist_nx = dist_q;
		unit_nx = unit_q;
		if (sum_q.conn) begin
			link_nx = 1'b1;
		end else if (sum_q.disc) begin
			link_nx = 1'b0;
			turn_nx = 3'd0;
		end
		if (!link_nx) begin
			st_nx = ST_NO_LINK;
		end else if (!sum_q.hdr_ok) begin
			st_nx = ST_NO_HEADER;
		end else if (crc_q != sum_q.rx_crc) begin
			st_nx = ST_BAD_CRC;
		end else begin
			st_nx = ST_UPDATED;
			dist_nx = sum_q.dist_m;
			unit_nx = (sum_q.dist_m > UNIT_LIMIT) ? UNIT_KM : UNIT_M;
			if (dmap[3])
				turn_nx = dmap[2:0];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sum_q <= head_sum;
			crc_q <= head_sum.crc;
			pad_q <= head_sum.pad;
		end else if (busy_q && pad_q != '0) begin
			// feed a zero byte for each one the frame was short
			crc_q <= crc_byte(crc_q, 8'h00);
			pad_q <= pad_q - 5'd1;
		end
		if (finish) begin
			st_q <= st_nx;
			conn_out_q <= link_nx;
			dir_out_q <= turn_nx;
			dist_out_q <= dist_nx;
			unit_out_q <= unit_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			link_q <= 1'b0;
			turn_q <= 3'd0;
			dist_q <= '0;
			unit_q <= UNIT_M;
			rv_q <= 1'b0;
		end else begin
			if (pop)
				busy_q <= 1'b1;
			else if (finish)
				busy_q <= 1'b0;
			if (finish) begin
				link_q <= link_nx;
				turn_q <= turn_nx;
				dist_q <= dist_nx;
				unit_q <= unit_nx;
				rv_q <= 1'b1;
			end else if (result_ready) begin
				rv_q <= 1'b0;
			end
		end
	end

	assign result_valid = rv_q;
	assign status = st_q;
	assign connected = conn_out_q;
	assign direction = dir_out_q;
	assign distance = dist_out_q;
	assign units = unit_out_q;

endmodule
`default_nettype wire

[hw/rtl/nav_frame_receiver.sv]
`default_nettype none
// channel   handshake                      payload
// input     data_valid / data_ready        data_byte, frame_end
// result    result_valid / result_ready    status, connected, direction, distance, units
//
// The front takes one byte per cycle while data_ready is high; CRC, header, fields and text
// match update per byte. The last byte of a frame pushes a summary into a two-entry queue;
// data_ready drops only while that queue is full. The back runs a zero byte through the CRC
// for each missing byte before byte 17, then loads the result register.
// Reset clears the link, direction and distance, sets units to meters, empties the queue.
module nav_frame_receiver #(
	parameter int unsigned MAX_FRAME = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        data_valid,
	output logic             data_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        frame_end,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [1:0]       status,
	output logic             connected,
	output logic [2:0]       direction,
	output logic [31:0]      distance,
	output logic [1:0]       units
);
	import nfr_pkg::*;

	logic       accept, push, full, pop, head_valid;
	frame_sum_t wr_sum, head_sum;

	assign data_ready = !full;
	assign accept = data_valid && data_ready;

	nfr_front #(.MAX_FRAME(MAX_FRAME)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.data_byte(data_byte),
		.frame_end(frame_end),
		.push(push),
		.sum(wr_sum)
	);

	nfr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_sum(wr_sum),
		.full(full),
		.pop(pop),
		.head_valid(head_valid),
		.head_sum(head_sum)
	);

	nfr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_sum(head_sum),
		.pop(pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.status(status),
		.connected(connected),
		.direction(direction),
		.distance(distance),
		.units(units)
	);

endmodule
`default_nettype wire
